// ----- design/kpq_pkg.sv -----
package kpq_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int KEY_BITS_DEF = 32;
   localparam int KIND_BITS    = 2;
   localparam int ITEM_BITS    = 32;
   localparam int SCORE_BITS   = 16;
   localparam int STATUS_BITS  = 2;

   localparam logic [KIND_BITS-1:0] KIND_RATE   = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_REMOVE = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_QUERY  = 2'd2;

   localparam logic [STATUS_BITS-1:0] STATUS_DONE      = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL      = 2'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY     = 2'd3;

   typedef struct packed {
      logic [KIND_BITS-1:0]  kind;
      logic [ITEM_BITS-1:0]  item_key;
      logic [SCORE_BITS-1:0] score;
   } kpq_req_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic                   top_valid;
      logic [ITEM_BITS-1:0]   top_key;
      logic [SCORE_BITS-1:0]  top_score;
   } kpq_rsp_type;

   // operation broadcast to every slot of the chain
   typedef struct packed {
      logic                  remove_en;
      logic                  insert_en;
      logic [SCORE_BITS-1:0] score;
   } kpq_ctrl_type;

endpackage

// ----- design/kpq_cell.sv -----
module kpq_cell #(
   parameter int KeyBits = kpq_pkg::KEY_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  kpq_pkg::kpq_ctrl_type           ctrl,
   input  logic [KeyBits-1:0]              new_key,
   input  logic                            left_valid,
   input  logic [KeyBits-1:0]              left_key,
   input  logic [kpq_pkg::SCORE_BITS-1:0]  left_score,
   input  logic                            left_ge,
   input  logic                            right_valid,
   input  logic [KeyBits-1:0]              right_key,
   input  logic [kpq_pkg::SCORE_BITS-1:0]  right_score,
   input  logic                            found_in,
   output logic                            found_out,
   output logic                            ge_out,
   output logic                            valid_out,
   output logic [KeyBits-1:0]              key_out,
   output logic [kpq_pkg::SCORE_BITS-1:0]  score_out,
   output logic                            next_valid,
   output logic [KeyBits-1:0]              next_key,
   output logic [kpq_pkg::SCORE_BITS-1:0]  next_score
);
   import kpq_pkg::*;

   logic                  valid_ff, valid_in;
   logic [KeyBits-1:0]    key_ff, key_in;
   logic [SCORE_BITS-1:0] score_ff, score_in;

   assign found_out = found_in | (valid_ff && key_ff == new_key);
   assign ge_out    = valid_ff && (score_ff >= ctrl.score);

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      score_in = score_ff;
      if (ctrl.remove_en && found_out) begin
         // close the hole: pull from the right
         valid_in = right_valid;
         key_in   = right_key;
         score_in = right_score;
      end else if (ctrl.insert_en && !ge_out) begin
         if (left_ge) begin
            valid_in = 1'b1;
            key_in   = new_key;
            score_in = ctrl.score;
         end else begin
            valid_in = left_valid;
            key_in   = left_key;
            score_in = left_score;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      key_ff   <= key_in;
      score_ff <= score_in;
   end

   assign valid_out  = valid_ff;
   assign key_out    = key_ff;
   assign score_out  = score_ff;
   assign next_valid = valid_in;
   assign next_key   = key_in;
   assign next_score = score_in;

endmodule

// ----- design/keyed_priority_queue_top.sv -----
// Keyed priority queue: holds up to Capacity key/rating entries sorted by
// rating, highest first, earlier insertion first among equal ratings. Pulse
// start with a transaction on req_data while busy is low; the result appears on
// rsp_data for exactly one cycle with rsp_strobe high and must be taken then,
// since the receiver cannot stall. A query or remove gets its result in the
// remove state, where the row of slots matches the key and closes its gap; a
// rate then goes on to the insert state, comparing ratings and shifting to open
// the insert position, unless the key is absent and the queue is full (status
// full). busy stays high until the result strobe, so the next transaction can
// be accepted at the edge that takes the result.
module keyed_priority_queue_top #(
   parameter int Capacity = kpq_pkg::CAPACITY_DEF,
   parameter int KeyBits  = kpq_pkg::KEY_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  kpq_pkg::kpq_req_type req_data,
   output logic                 rsp_strobe,
   output kpq_pkg::kpq_rsp_type rsp_data
);
   import kpq_pkg::*;

   localparam int CountBits = $clog2(Capacity + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REMOVE,
      ST_INSERT
   } state_type;

   state_type            state_ff;
   kpq_req_type          req_ff;
   logic [CountBits-1:0] count_ff;
   logic                 rsp_strobe_ff;
   kpq_rsp_type          rsp_ff;

   kpq_ctrl_type          ctrl;
   logic [KeyBits-1:0]    new_key;
   logic                  found;
   logic                  full;
   kpq_rsp_type           top_now;

   logic                  found_c [0:Capacity];
   logic                  ge_c    [0:Capacity];
   logic                  val_a   [0:Capacity];
   logic [KeyBits-1:0]    key_a   [0:Capacity];
   logic [SCORE_BITS-1:0] score_a [0:Capacity];
   logic                  nxt_valid [0:Capacity-1];
   logic [KeyBits-1:0]    nxt_key   [0:Capacity-1];
   logic [SCORE_BITS-1:0] nxt_score [0:Capacity-1];

   assign new_key        = KeyBits'(req_ff.item_key);
   assign ctrl.remove_en = (state_ff == ST_REMOVE) &&
                           (req_ff.kind == KIND_RATE || req_ff.kind == KIND_REMOVE);
   assign ctrl.insert_en = (state_ff == ST_INSERT);
   assign ctrl.score     = req_ff.score;

   assign found_c[0]        = 1'b0;
   assign ge_c[0]           = 1'b1;
   assign val_a[Capacity]   = 1'b0;
   assign key_a[Capacity]   = '0;
   assign score_a[Capacity] = '0;

   genvar g;
   generate
      for (g = 0; g < Capacity; g++) begin : g_slot
         logic                  lv;
         logic [KeyBits-1:0]    lk;
         logic [SCORE_BITS-1:0] ls;
         if (g == 0) begin : g_first
            assign lv = 1'b0;
            assign lk = '0;
            assign ls = '0;
         end else begin : g_rest
            assign lv = val_a[g-1];
            assign lk = key_a[g-1];
            assign ls = score_a[g-1];
         end
         kpq_cell #(.KeyBits(KeyBits)) u_slot (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .new_key     (new_key),
            .left_valid  (lv),
            .left_key    (lk),
            .left_score  (ls),
            .left_ge     (ge_c[g]),
            .right_valid (val_a[g+1]),
            .right_key   (key_a[g+1]),
            .right_score (score_a[g+1]),
            .found_in    (found_c[g]),
            .found_out   (found_c[g+1]),
            .ge_out      (ge_c[g+1]),
            .valid_out   (val_a[g]),
            .key_out     (key_a[g]),
            .score_out   (score_a[g]),
            .next_valid  (nxt_valid[g]),
            .next_key    (nxt_key[g]),
            .next_score  (nxt_score[g])
         );
      end
   endgenerate

   assign found = found_c[Capacity];
   assign full  = (count_ff == CountBits'(Capacity));

   // result as it stands after this cycle's update
   always_comb begin
      top_now.status = STATUS_DONE;
      if (state_ff == ST_REMOVE) begin
         case (req_ff.kind)
            KIND_RATE:   top_now.status = STATUS_FULL;
            KIND_REMOVE: top_now.status = found ? STATUS_DONE : STATUS_NOT_FOUND;
            default:     top_now.status = (count_ff == '0) ? STATUS_EMPTY : STATUS_DONE;
         endcase
      end
      top_now.top_valid = nxt_valid[0];
      top_now.top_key   = nxt_valid[0] ? ITEM_BITS'(nxt_key[0]) : '0;
      top_now.top_score = nxt_valid[0] ? nxt_score[0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  req_ff   <= req_data;
                  state_ff <= ST_REMOVE;
               end
            end
            ST_REMOVE: begin
               if (ctrl.remove_en && found) begin
                  count_ff <= count_ff - CountBits'(1);
               end
               if (req_ff.kind == KIND_RATE && (found || !full)) begin
                  state_ff <= ST_INSERT;
               end else begin
                  rsp_strobe_ff <= 1'b1;
                  rsp_ff        <= top_now;
                  state_ff      <= ST_IDLE;
               end
            end
            ST_INSERT: begin
               count_ff      <= count_ff + CountBits'(1);
               rsp_strobe_ff <= 1'b1;
               rsp_ff        <= top_now;
               state_ff      <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
   import kpq_pkg::*;

   localparam int CAPACITY     = CAPACITY_DEF;
   localparam int KEY_BITS     = KEY_BITS_DEF;
   localparam int POOL_SIZE    = 96;
   localparam int RANDOM_ITEMS = 650;
   localparam int IDLE_LIMIT   = 200;
   localparam int SETTLE_CYCLES = 10;
   localparam int MAX_REPORTS  = 10;

   localparam logic [ITEM_BITS-1:0] KEY_MASK = {ITEM_BITS{1'b1}} >> (ITEM_BITS - KEY_BITS);
   // the block decodes kind value three as a query
   localparam logic [KIND_BITS-1:0] KIND_QUERY_ALT = 2'd3;

   localparam int MODE_FILL  = 0;
   localparam int MODE_DRAIN = 1;
   localparam int MODE_MIXED = 2;

   typedef struct packed {
      kpq_req_type req;
      logic        typed_exp;
      kpq_rsp_type rsp;
   } dir_row_type;

   localparam int NUM_DIR = 23;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   kpq_req_type req_data;
   logic        rsp_strobe;
   kpq_rsp_type rsp_data;

   // shadow copy of the sorted store
   logic [ITEM_BITS-1:0]  held_keys   [CAPACITY];
   logic [SCORE_BITS-1:0] held_scores [CAPACITY];
   int                    held_count;

   logic [ITEM_BITS-1:0] key_pool [POOL_SIZE];
   kpq_rsp_type          pending_tops [$];
   int                   mismatch_count;
   int                   idle_cycles;

   dir_row_type dir_tbl [NUM_DIR] = '{
      '{'{KIND_QUERY,     32'h0000_1234, 16'hBEEF}, 1'b1,
        '{STATUS_EMPTY, 1'b0, 32'h0, 16'h0}},
      '{'{KIND_REMOVE,    32'h0000_0005, 16'h0001}, 1'b1,
        '{STATUS_NOT_FOUND, 1'b0, 32'h0, 16'h0}},
      '{'{KIND_QUERY_ALT, 32'hFFFF_FFFF, 16'hFFFF}, 1'b1,
        '{STATUS_EMPTY, 1'b0, 32'h0, 16'h0}},
      '{'{KIND_RATE,      32'h0000_0000, 16'h0000}, 1'b1,
        '{STATUS_DONE, 1'b1, 32'h0, 16'h0}},
      '{'{KIND_RATE,      32'hFFFF_FFFF, 16'hFFFF}, 1'b1,
        '{STATUS_DONE, 1'b1, 32'hFFFF_FFFF, 16'hFFFF}},
      '{'{KIND_RATE,      32'h0000_000A, 16'hFFFF}, 1'b1,
        '{STATUS_DONE, 1'b1, 32'hFFFF_FFFF, 16'hFFFF}},
      '{'{KIND_REMOVE,    32'hFFFF_FFFF, 16'h1234}, 1'b1,
        '{STATUS_DONE, 1'b1, 32'h0000_000A, 16'hFFFF}},
      '{'{KIND_RATE,      32'h0000_000A, 16'h0000}, 1'b0, '0},
      '{'{KIND_REMOVE,    32'h0000_0000, 16'h00FF}, 1'b0, '0},
      '{'{KIND_REMOVE,    32'h0000_0000, 16'h0000}, 1'b0, '0},
      '{'{KIND_RATE,      32'h0000_0014, 16'd100},  1'b0, '0},
      '{'{KIND_RATE,      32'h0000_001E, 16'd100},  1'b0, '0},
      '{'{KIND_RATE,      32'h0000_0014, 16'd100},  1'b0, '0},
      '{'{KIND_QUERY,     32'h8000_0001, 16'h7FFF}, 1'b0, '0},
      '{'{KIND_QUERY_ALT, 32'h0000_0000, 16'h0000}, 1'b0, '0},
      '{'{KIND_RATE,      32'hAAAA_AAAA, 16'h5555}, 1'b0, '0},
      '{'{KIND_RATE,      32'h5555_5555, 16'hAAAA}, 1'b0, '0},
      '{'{KIND_REMOVE,    32'h0000_001E, 16'h0000}, 1'b0, '0},
      '{'{KIND_REMOVE,    32'h0000_0014, 16'h0000}, 1'b0, '0},
      '{'{KIND_REMOVE,    32'h0000_000A, 16'h0000}, 1'b0, '0},
      '{'{KIND_REMOVE,    32'hAAAA_AAAA, 16'h0000}, 1'b0, '0},
      '{'{KIND_REMOVE,    32'h5555_5555, 16'hFFFF}, 1'b1,
        '{STATUS_DONE, 1'b0, 32'h0, 16'h0}},
      '{'{KIND_QUERY,     32'h0000_0000, 16'h0000}, 1'b1,
        '{STATUS_EMPTY, 1'b0, 32'h0, 16'h0}}
   };

   keyed_priority_queue_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // close the gap left by a removed entry
   function automatic void drop_slot(int slot);
      int i;
      for (i = slot; i + 1 < held_count; i++) begin
         held_keys[i]   = held_keys[i + 1];
         held_scores[i] = held_scores[i + 1];
      end
      held_count--;
   endfunction

   // insert behind every entry rated greater than or equal
   function automatic void place_entry(logic [ITEM_BITS-1:0] key, logic [SCORE_BITS-1:0] score);
      int pos;
      int i;
      pos = 0;
      while (pos < held_count && held_scores[pos] >= score) pos++;
      for (i = held_count; i > pos; i--) begin
         held_keys[i]   = held_keys[i - 1];
         held_scores[i] = held_scores[i - 1];
      end
      held_keys[pos]   = key;
      held_scores[pos] = score;
      held_count++;
   endfunction

   function automatic kpq_rsp_type next_top_entry(kpq_req_type req);
      logic [ITEM_BITS-1:0] key;
      kpq_rsp_type          top;
      int                   slot;
      int                   i;
      key  = req.item_key & KEY_MASK;
      top  = '0;
      top.status = STATUS_DONE;
      slot = -1;
      for (i = 0; i < held_count; i++) begin
         if (slot < 0 && held_keys[i] == key) slot = i;
      end
      case (req.kind)
         KIND_RATE: begin
            if (slot >= 0) begin
               drop_slot(slot);
               place_entry(key, req.score);
            end else if (held_count >= CAPACITY) begin
               top.status = STATUS_FULL;
            end else begin
               place_entry(key, req.score);
            end
         end
         KIND_REMOVE: begin
            if (slot >= 0) drop_slot(slot);
            else top.status = STATUS_NOT_FOUND;
         end
         default: begin
            if (held_count == 0) top.status = STATUS_EMPTY;
         end
      endcase
      if (held_count > 0) begin
         top.top_valid = 1'b1;
         top.top_key   = held_keys[0];
         top.top_score = held_scores[0];
      end
      return top;
   endfunction

   function automatic logic [ITEM_BITS-1:0] pick_key(int present_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < present_pct && held_count > 0) return held_keys[$urandom_range(0, held_count - 1)];
      else if (r < 90) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
      else return $urandom;
   endfunction

   function automatic kpq_req_type random_txn(int mode);
      kpq_req_type t;
      int          pick;
      int          rate_pct;
      int          remove_pct;
      case (mode)
         MODE_FILL: begin
            rate_pct   = 85;
            remove_pct = 10;
         end
         MODE_DRAIN: begin
            rate_pct   = 25;
            remove_pct = 60;
         end
         default: begin
            rate_pct   = 50;
            remove_pct = 35;
         end
      endcase
      // small ratings make ties common
      case ($urandom_range(0, 3))
         1:       t.score = $urandom_range(0, 7);
         2:       t.score = $urandom_range(0, 1) ? '1 : '0;
         default: t.score = $urandom;
      endcase
      pick = $urandom_range(0, 99);
      if (pick < rate_pct) begin
         t.kind     = KIND_RATE;
         t.item_key = pick_key(15);
      end else if (pick < rate_pct + remove_pct) begin
         t.kind     = KIND_REMOVE;
         t.item_key = pick_key(65);
      end else begin
         t.kind     = $urandom_range(0, 1) ? KIND_QUERY : KIND_QUERY_ALT;
         t.item_key = $urandom;
      end
      return t;
   endfunction

   // entered and left at a falling edge
   task automatic send_txn(kpq_req_type req, kpq_rsp_type top, int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= req;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_tops.push_back(top);
      @(negedge clock);
   endtask

   task automatic log_mismatch(string what, kpq_rsp_type want, kpq_rsp_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $write("%0t: %s: expected status=%0d valid=%0b key=%h score=%h",
                $realtime, what, want.status, want.top_valid, want.top_key, want.top_score);
         $display(", got status=%0d valid=%0b key=%h score=%h",
                  got.status, got.top_valid, got.top_key, got.top_score);
      end
   endtask

   always @(posedge clock) begin
      kpq_rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_tops.size() == 0) begin
            log_mismatch("unexpected transaction", '0, rsp_data);
         end else begin
            want = pending_tops.pop_front();
            if (rsp_data.status !== want.status || rsp_data.top_valid !== want.top_valid ||
                rsp_data.top_key !== want.top_key || rsp_data.top_score !== want.top_score) begin
               log_mismatch("result mismatch", want, rsp_data);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("keyed_priority_queue_top verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      kpq_req_type txn;
      kpq_rsp_type top;
      int          sent;
      int          phase;
      int          phase_len;
      int          mode;
      bit          no_gaps;
      int          i;
      reset          = 1'b1;
      start          = 1'b0;
      req_data       = '0;
      held_count     = 0;
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < NUM_DIR; i++) begin
         top = next_top_entry(dir_tbl[i].req);
         if (dir_tbl[i].typed_exp) top = dir_tbl[i].rsp;
         send_txn(dir_tbl[i].req, top, $urandom_range(0, 8));
      end

      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         // hold the sender until every result is back
         start <= 1'b0;
         do @(negedge clock); while (pending_tops.size() != 0);
         mode      = (phase == 0) ? MODE_FILL : $urandom_range(MODE_FILL, MODE_MIXED);
         phase_len = (phase == 0) ? 110 : $urandom_range(30, 80);
         no_gaps   = ($urandom_range(0, 3) == 0);
         for (i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
            txn = random_txn(mode);
            top = next_top_entry(txn);
            send_txn(txn, top, no_gaps ? 0 : $urandom_range(0, 8));
            sent++;
         end
         phase++;
      end

      start <= 1'b0;
      while (pending_tops.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("keyed_priority_queue_top verification clean");
      end else begin
         $display("keyed_priority_queue_top verification failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
design/kpq_pkg.sv
design/kpq_cell.sv
design/keyed_priority_queue_top.sv
tb/tb_top.sv
